>>> rtl/assert_macros.svh
// Assertion macros shared by the residual unit RTL.
// Modules that include this file must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PRM_ASSERT(label, prop, msg)
`define PRM_ASSERT_NEVER(label, cond, msg)
`endif
`endif

>>> rtl/prm_pkg.sv
// Package for the residual max-norm unit: widths, reset values, register codes
// and the per-beat control struct. No dependencies.
package prm_pkg;

  localparam int GRID_W = 6;
  localparam int INV_W  = 20;
  localparam int RES_W  = 47;

  localparam logic [GRID_W-1:0] GRID_SIZE_RST = 6'd60;
  localparam logic [INV_W-1:0]  INV_STEP_RST  = 20'd3600;
  localparam logic [RES_W-1:0]  RES_LIMIT     = {RES_W{1'b1}};

  typedef enum logic [0:0] {
    REG_GRID_SIZE   = 1'b0,
    REG_INV_STEP_SQ = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic calc;
    logic last;
  } item_ctl_t;

endpackage

>>> rtl/prm_in_if.sv
// Input stream interface: one grid point (u and f samples) per beat.
// Standalone; sample width set by SAMPLE_BITS.
interface prm_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] u_sample;
  logic signed [SAMPLE_BITS-1:0] f_sample;

  modport source (output valid, output u_sample, output f_sample, input ready);
  modport sink (input valid, input u_sample, input f_sample, output ready);
endinterface

>>> rtl/prm_out_if.sv
// Result stream interface: maximum residual and saturation flag per beat.
// Depends on prm_pkg for the result width.
interface prm_out_if;
  logic                       valid;
  logic                       ready;
  logic [prm_pkg::RES_W-1:0]  max_residual;
  logic                       saturated;

  modport source (output valid, output max_residual, output saturated, input ready);
  modport sink (input valid, input max_residual, input saturated, output ready);
endinterface

>>> rtl/poisson_residual_max_norm_unit.sv
// Five-point Laplacian residual max-norm over a streamed (grid_size+1)^2 grid of
// u and f samples in raster order. Takes one point per cycle unless stalled; the
// result beat for a grid is produced after its last point is accepted, through
// a three-stage pipeline (stencil sum, 1/h^2 multiply, add f and clamp) and the
// result register. A waiting result stalls the input only once the next grid's
// last point reaches the final stage and two more points fill the stages behind
// it. The line store needs no clearing after reset.
module poisson_residual_max_norm_unit #(
  parameter int MAX_POINTS  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  prm_in_if.sink      in_ch,
  prm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [prm_pkg::GRID_W-1:0] grid_r;
  logic [prm_pkg::INV_W-1:0]  inv_r;
  logic [prm_pkg::GRID_W-1:0] row_r;
  logic [prm_pkg::GRID_W-1:0] col_r;
  logic [prm_pkg::GRID_W-1:0] row_nxt;
  logic [prm_pkg::GRID_W-1:0] col_nxt;

  prm_pkg::reg_idx_t          reg_idx;
  logic                       cfg_wr;
  logic                       in_rdy;
  logic                       acc;
  prm_pkg::item_ctl_t         ctl;
  logic [prm_pkg::GRID_W:0]   col_ext;
  logic [prm_pkg::GRID_W:0]   grid_ext;

  logic signed [SAMPLE_BITS-1:0] u_n;
  logic signed [SAMPLE_BITS-1:0] u_w;
  logic signed [SAMPLE_BITS-1:0] u_c;
  logic signed [SAMPLE_BITS-1:0] u_e;
  logic signed [SAMPLE_BITS-1:0] f_c;

  logic                       res_vld;
  logic                       res_rdy;
  logic [prm_pkg::RES_W-1:0]  res;
  prm_pkg::item_ctl_t         res_ctl;

  assign pready  = 1'b1;
  assign reg_idx = prm_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= prm_pkg::GRID_SIZE_RST;
      inv_r  <= prm_pkg::INV_STEP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        prm_pkg::REG_GRID_SIZE:   grid_r <= pwdata[prm_pkg::GRID_W-1:0];
        prm_pkg::REG_INV_STEP_SQ: inv_r  <= pwdata[prm_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      prm_pkg::REG_GRID_SIZE:   prdata = 32'(grid_r);
      prm_pkg::REG_INV_STEP_SQ: prdata = 32'(inv_r);
      default:                  prdata = '0;
    endcase
  end

  assign acc         = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  assign col_ext  = (prm_pkg::GRID_W + 1)'(col_r);
  assign grid_ext = (prm_pkg::GRID_W + 1)'(grid_r);
  assign ctl.calc = (row_r >= 6'd2) && (col_r != '0) && ((col_ext + 1'b1) <= grid_ext);
  assign ctl.last = (row_r >= grid_r) && (col_r >= grid_r);

  always_comb begin
    if (ctl.last) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (col_r >= grid_r) begin
      row_nxt = row_r + 1'b1;
      col_nxt = '0;
    end else begin
      row_nxt = row_r;
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  prm_line_buf #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line_buf (
    .clk      (clk),
    .acc      (acc),
    .col      (col_r),
    .col_step (col_nxt),
    .u_in     (in_ch.u_sample),
    .f_in     (in_ch.f_sample),
    .u_n      (u_n),
    .u_w      (u_w),
    .u_c      (u_c),
    .u_e      (u_e),
    .f_c      (f_c)
  );

  prm_resid_pipe #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_resid_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_rdy  (in_rdy),
    .in_ctl  (ctl),
    .u_n     (u_n),
    .u_w     (u_w),
    .u_c     (u_c),
    .u_e     (u_e),
    .u_s     (in_ch.u_sample),
    .f_c     (f_c),
    .inv     (inv_r),
    .res_vld (res_vld),
    .res_rdy (res_rdy),
    .res     (res),
    .res_ctl (res_ctl)
  );

  prm_max_track u_max_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_vld (res_vld),
    .res_rdy (res_rdy),
    .res     (res),
    .res_ctl (res_ctl),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/prm_line_buf.sv
// Line store and stencil window: two rows of u and one row of f per column,
// prefetched one beat ahead through two registered read ports. Uses prm_pkg.
module prm_line_buf #(
  parameter int MAX_POINTS  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          acc,
  input  logic [prm_pkg::GRID_W-1:0]    col,
  input  logic [prm_pkg::GRID_W-1:0]    col_step,
  input  logic signed [SAMPLE_BITS-1:0] u_in,
  input  logic signed [SAMPLE_BITS-1:0] f_in,
  output logic signed [SAMPLE_BITS-1:0] u_n,
  output logic signed [SAMPLE_BITS-1:0] u_w,
  output logic signed [SAMPLE_BITS-1:0] u_c,
  output logic signed [SAMPLE_BITS-1:0] u_e,
  output logic signed [SAMPLE_BITS-1:0] f_c
);

  localparam int AW = $clog2(MAX_POINTS);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] u1;
    logic signed [SAMPLE_BITS-1:0] u2;
    logic signed [SAMPLE_BITS-1:0] f;
  } line_word_t;

  line_word_t                    mem [MAX_POINTS];
  line_word_t                    cw_r;
  line_word_t                    rd_r;
  logic                          cw_ok_r;
  logic                          rd_ok_r;
  logic signed [SAMPLE_BITS-1:0] west_r;

  logic [prm_pkg::GRID_W:0] col_ahead;
  logic [AW-1:0]            ra;
  logic [AW-1:0]            rb;
  logic [AW-1:0]            wa;
  logic                     ra_ok;
  logic                     rb_ok;
  logic                     wr_ok;

  assign col_ahead = (prm_pkg::GRID_W + 1)'(col_step) + 1'b1;
  assign ra        = AW'(col_step);
  assign rb        = AW'(col_ahead);
  assign wa        = AW'(col);
  assign ra_ok     = 32'(col_step) < 32'(MAX_POINTS);
  assign rb_ok     = 32'(col_ahead) < 32'(MAX_POINTS);
  assign wr_ok     = 32'(col) < 32'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (acc) begin
      cw_r    <= mem[ra];
      rd_r    <= mem[rb];
      cw_ok_r <= ra_ok;
      rd_ok_r <= rb_ok;
      west_r  <= u_c;
      if (wr_ok) begin
        mem[wa] <= {u_in, cw_r.u1, f_in};
      end
    end
  end

  assign u_n = cw_ok_r ? cw_r.u2 : '0;
  assign u_c = cw_ok_r ? cw_r.u1 : '0;
  assign f_c = cw_ok_r ? cw_r.f : '0;
  assign u_e = rd_ok_r ? rd_r.u1 : '0;
  assign u_w = west_r;

endmodule

>>> rtl/prm_resid_pipe.sv
// Three-stage residual pipeline: Laplacian sum, scale by 1/h^2, add f and
// take the clamped magnitude. Uses prm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module prm_resid_pipe #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  prm_pkg::item_ctl_t            in_ctl,
  input  logic signed [SAMPLE_BITS-1:0] u_n,
  input  logic signed [SAMPLE_BITS-1:0] u_w,
  input  logic signed [SAMPLE_BITS-1:0] u_c,
  input  logic signed [SAMPLE_BITS-1:0] u_e,
  input  logic signed [SAMPLE_BITS-1:0] u_s,
  input  logic signed [SAMPLE_BITS-1:0] f_c,
  input  logic [prm_pkg::INV_W-1:0]     inv,
  output logic                          res_vld,
  input  logic                          res_rdy,
  output logic [prm_pkg::RES_W-1:0]     res,
  output prm_pkg::item_ctl_t            res_ctl
);

  localparam int LW = SAMPLE_BITS + 3;
  localparam int PW = LW + prm_pkg::INV_W + 1;
  localparam int SW = PW + 1;
  localparam int CW = (SW > prm_pkg::RES_W) ? SW : prm_pkg::RES_W + 1;

  logic                          v1_r;
  logic                          v2_r;
  logic                          v3_r;
  logic signed [LW-1:0]          lap_r;
  logic signed [SAMPLE_BITS-1:0] f1_r;
  logic signed [SAMPLE_BITS-1:0] f2_r;
  prm_pkg::item_ctl_t            ctl1_r;
  prm_pkg::item_ctl_t            ctl2_r;
  prm_pkg::item_ctl_t            ctl3_r;
  logic signed [PW-1:0]          prod_r;
  logic [prm_pkg::RES_W-1:0]     res_r;

  logic signed [LW-1:0]          lap_nxt;
  logic signed [PW-1:0]          prod_nxt;
  logic signed [SW-1:0]          sum_w;
  logic [SW-1:0]                 abs_w;
  logic [CW-1:0]                 abs_ext;
  logic [prm_pkg::RES_W-1:0]     res_nxt;
  logic                          adv1;
  logic                          adv2;
  logic                          adv3;

  assign adv3   = !v3_r || res_rdy;
  assign adv2   = !v2_r || adv3;
  assign adv1   = !v1_r || adv2;
  assign in_rdy = adv1;

  assign lap_nxt = LW'(u_n) + LW'(u_w) + LW'(u_e) + LW'(u_s) - (LW'(u_c) <<< 2);
  assign prod_nxt = lap_r * $signed({1'b0, inv});
  assign sum_w    = SW'(prod_r) + SW'(f2_r);
  assign abs_w    = sum_w[SW-1] ? SW'(-sum_w) : SW'(sum_w);
  assign abs_ext  = CW'(abs_w);
  assign res_nxt  = (abs_ext > CW'(prm_pkg::RES_LIMIT)) ? prm_pkg::RES_LIMIT
                                                        : prm_pkg::RES_W'(abs_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_vld;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_vld) begin
      lap_r  <= lap_nxt;
      f1_r   <= f_c;
      ctl1_r <= in_ctl;
    end
    if (adv2 && v1_r) begin
      prod_r <= prod_nxt;
      f2_r   <= f1_r;
      ctl2_r <= ctl1_r;
    end
    if (adv3 && v2_r) begin
      res_r  <= res_nxt;
      ctl3_r <= ctl2_r;
    end
  end

  assign res_vld = v3_r;
  assign res     = res_r;
  assign res_ctl = ctl3_r;

  `PRM_ASSERT_NEVER(a_stall_only_when_full, !in_rdy && !(v1_r && v2_r && v3_r),
                    "input stalled with a free pipeline stage")
  `PRM_ASSERT(a_stage3_holds, (v3_r && !res_rdy) |=> (v3_r && $stable(res_r)),
              "stage 3 result changed while held")

endmodule

>>> rtl/prm_max_track.sv
// Running maximum of the residual magnitude and the result register.
// Uses prm_pkg, prm_out_if and assert_macros.svh.
`include "assert_macros.svh"
module prm_max_track (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      res_vld,
  output logic                      res_rdy,
  input  logic [prm_pkg::RES_W-1:0] res,
  input  prm_pkg::item_ctl_t        res_ctl,
  prm_out_if.source                 out_ch
);

  logic [prm_pkg::RES_W-1:0] max_r;
  logic [prm_pkg::RES_W-1:0] max_nxt;
  logic [prm_pkg::RES_W-1:0] max_upd;
  logic                      out_v_r;
  logic                      out_v_nxt;
  logic [prm_pkg::RES_W-1:0] out_max_r;
  logic                      out_sat_r;
  logic                      take;
  logic                      emit;

  assign res_rdy = !res_ctl.last || !out_v_r || out_ch.ready;
  assign take    = res_vld && res_rdy;
  assign emit    = take && res_ctl.last;
  assign max_upd = (res_ctl.calc && (res > max_r)) ? res : max_r;

  always_comb begin
    max_nxt = max_r;
    if (take) begin
      max_nxt = res_ctl.last ? '0 : max_upd;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      max_r   <= max_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_max_r <= max_upd;
      out_sat_r <= (max_upd == prm_pkg::RES_LIMIT);
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.max_residual = out_max_r;
  assign out_ch.saturated    = out_sat_r;

  `PRM_ASSERT(a_sat_flag, out_v_r |-> (out_sat_r == (out_max_r == prm_pkg::RES_LIMIT)),
              "saturated flag disagrees with result")
  `PRM_ASSERT(a_max_monotonic, (take && !res_ctl.last) |=> (max_r >= $past(max_r)),
              "running maximum decreased within a grid")
  `PRM_ASSERT(a_clear_on_emit, emit |=> ((max_r == '0) && out_v_r),
              "maximum not cleared or result not posted after last point")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for poisson_residual_max_norm_unit: streams square grids over the input channel,
// sets grid size and 1/h^2 over APB, and checks each max-norm beat against a local predictor.
// Depends on prm_pkg, prm_in_if, prm_out_if and the unit RTL.
module testbench;

  localparam int MAX_POINTS = 64;
  localparam int SAMPLE_W   = 24;
  localparam int CYCLE_LIMIT = 500000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;
  localparam logic [prm_pkg::INV_W-1:0] INV_MAX = {prm_pkg::INV_W{1'b1}};

  typedef enum int {FILL_FULL, FILL_SMALL, FILL_MIXED, FILL_PEAK, FILL_FLAT} fill_style_t;

  typedef struct {
    logic [prm_pkg::RES_W-1:0] max_residual;
    logic                      saturated;
  } max_norm_t;

  class max_norm_scoreboard;
    logic [prm_pkg::GRID_W-1:0] grid_n;
    logic [prm_pkg::INV_W-1:0]  inv_sq;
    sample_t                    u_rows [0:2*MAX_POINTS-1];
    sample_t                    f_row [0:MAX_POINTS-1];
    logic [prm_pkg::GRID_W-1:0] row_idx;
    logic [prm_pkg::GRID_W-1:0] col_idx;
    longint                     peak;
    max_norm_t                  expected_maxima [$];
    int                         failures;
    int                         results_seen;

    function new();
      grid_n = prm_pkg::GRID_SIZE_RST;
      inv_sq = prm_pkg::INV_STEP_RST;
      foreach (u_rows[i]) u_rows[i] = '0;
      foreach (f_row[i]) f_row[i] = '0;
      row_idx = '0;
      col_idx = '0;
      peak = 0;
      failures = 0;
      results_seen = 0;
    endfunction

    function void set_register(prm_pkg::reg_idx_t idx, logic [31:0] value);
      if (idx == prm_pkg::REG_GRID_SIZE) grid_n = value[prm_pkg::GRID_W-1:0];
      else if (idx == prm_pkg::REG_INV_STEP_SQ) inv_sq = value[prm_pkg::INV_W-1:0];
    endfunction

    function void note_point(sample_t u, sample_t f);
      int n, r, c, cur, prev;
      longint lap, res;
      max_norm_t beat;
      n = int'(grid_n);
      r = int'(row_idx);
      c = int'(col_idx);
      cur = r & 1;
      prev = (r + 1) & 1;
      if (r >= 2 && c >= 1 && c + 1 <= n) begin
        lap = longint'(u_rows[cur*MAX_POINTS + c]) + longint'(u_rows[prev*MAX_POINTS + c - 1])
            + longint'(u_rows[prev*MAX_POINTS + c + 1]) + longint'(u)
            - 4 * longint'(u_rows[prev*MAX_POINTS + c]);
        res = lap * longint'(inv_sq) + longint'(f_row[c]);
        if (res < 0) res = -res;
        if (res > longint'(prm_pkg::RES_LIMIT)) res = longint'(prm_pkg::RES_LIMIT);
        if (res > peak) peak = res;
      end
      if (c < MAX_POINTS) begin
        u_rows[cur*MAX_POINTS + c] = u;
        f_row[c] = f;
      end
      if (r >= n && c >= n) begin
        beat.max_residual = peak[prm_pkg::RES_W-1:0];
        beat.saturated = (peak == longint'(prm_pkg::RES_LIMIT));
        expected_maxima.push_back(beat);
        peak = 0;
        row_idx = '0;
        col_idx = '0;
      end else if (c >= n) begin
        col_idx = '0;
        row_idx = row_idx + 1'b1;
      end else begin
        col_idx = col_idx + 1'b1;
      end
    endfunction

    function void check_result(logic [prm_pkg::RES_W-1:0] max_residual, logic saturated);
      max_norm_t want;
      results_seen++;
      if (expected_maxima.size() == 0) begin
        $error("max_residual: no grid pending, actual %0d", max_residual);
        failures++;
        return;
      end
      want = expected_maxima.pop_front();
      if (max_residual !== want.max_residual) begin
        $error("max_residual: expected %0d, actual %0d", want.max_residual, max_residual);
        failures++;
      end
      if (saturated !== want.saturated) begin
        $error("saturated: expected %0d, actual %0d", want.saturated, saturated);
        failures++;
      end
    endfunction

    function int pending();
      return expected_maxima.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  prm_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_bus();
  prm_out_if out_bus();

  poisson_residual_max_norm_unit #(
    .MAX_POINTS(MAX_POINTS),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  max_norm_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int points_accepted = 0;
  int cycles = 0;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      sb.note_point(in_bus.u_sample, in_bus.f_sample);
      points_accepted++;
    end
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_result(out_bus.max_residual,
                                                                 out_bus.saturated);
  end

  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_point(input sample_t u, input sample_t f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.u_sample <= u;
    in_bus.f_sample <= f;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic sample_t pick_sample(fill_style_t style);
    if (style == FILL_SMALL) return sample_t'(int'($urandom_range(0, 1023)) - 512);
    if (style == FILL_MIXED) begin
      case ($urandom_range(0, 5))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return '0;
        3: return '1;
        default: return sample_t'($urandom);
      endcase
    end
    return sample_t'($urandom);
  endfunction

  task automatic send_grid(input int n, input fill_style_t style);
    sample_t u, f;
    for (int r = 0; r <= n; r++) begin
      for (int c = 0; c <= n; c++) begin
        if (style == FILL_PEAK) begin
          u = ((r + c) & 1) ? SAMPLE_MAX : SAMPLE_MIN;
          f = SAMPLE_MAX;
        end else if (style == FILL_FLAT) begin
          u = SAMPLE_MAX;
          f = SAMPLE_MIN;
        end else begin
          u = pick_sample(style);
          f = pick_sample(style);
        end
        send_point(u, f);
      end
    end
  endtask

  task automatic write_reg(input prm_pkg::reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(int'(idx) << 2);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold off until the last grid's beat is out and the pipeline has emptied
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(input int n, input logic [prm_pkg::INV_W-1:0] inv);
    wait_idle();
    write_reg(prm_pkg::REG_GRID_SIZE, 32'(n));
    write_reg(prm_pkg::REG_INV_STEP_SQ, 32'(inv));
  endtask

  initial begin
    int n;
    int start_points;
    int start_results;
    logic [prm_pkg::INV_W-1:0] inv;
    fill_style_t style;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.u_sample = '0;
    in_bus.f_sample = '0;
    out_bus.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no interior: every point closes a grid, then a 2x2 grid with none
    configure(0, prm_pkg::INV_STEP_RST);
    send_grid(0, FILL_FULL);
    send_grid(0, FILL_FULL);
    configure(1, 1);
    send_grid(1, FILL_FULL);
    // largest stencil magnitude, then flat u so only f counts
    configure(2, INV_MAX);
    send_grid(2, FILL_PEAK);
    configure(2, 0);
    send_grid(2, FILL_FLAT);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 10 : 0;
      start_points = points_accepted;
      start_results = sb.results_seen;
      while (points_accepted - start_points < 230 || sb.results_seen - start_results < 10) begin
        if ($urandom_range(0, 19) == 0) begin
          n = $urandom_range(7, 12);
        end else begin
          n = $urandom_range(2, 5);
        end
        case ($urandom_range(0, 5))
          0: inv = '0;
          1: inv = INV_MAX;
          2: inv = prm_pkg::INV_W'($urandom_range(1, 16));
          default: inv = prm_pkg::INV_W'($urandom_range(0, 1048575));
        endcase
        configure(n, inv);
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0: style = FILL_SMALL;
            1: style = FILL_MIXED;
            default: style = FILL_FULL;
          endcase
          send_grid(n, style);
        end
        wait_idle();
      end
    end

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
